// ----- rtl/shfir_pkg.sv -----
// Shared types and constants for the stereo impulse response FIR convolver.
// Used by shfir_mac and stereo_hrir_fir_convolver; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package shfir_pkg;

    localparam int unsigned SAMPLE_BITS     = 16;
    localparam int unsigned MAX_TAPS_DEF    = 256;
    localparam int unsigned TAP_INDEX_W     = 8;
    localparam int unsigned TAP_COUNT_W     = 9;
    localparam int unsigned TAP_COUNT_RESET = 256;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register index, taken from paddr above the byte offset.
    localparam logic [APB_ADDR_W-3:0] REG_TAP_COUNT = '0;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    typedef struct packed {
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic [TAP_INDEX_W-1:0]        tap_index;
        logic signed [SAMPLE_BITS-1:0] tap_left;
        logic signed [SAMPLE_BITS-1:0] tap_right;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_out_item;

    // Control that travels with each tap beat through the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/shfir_mac.sv -----
// Two-channel multiply-accumulate unit with round-half-up and saturation.
// Depends on shfir_pkg for the beat control struct and the sample width.
`timescale 1ns / 1ps
`default_nettype none

module shfir_mac #(
    parameter int unsigned MAX_TAPS = shfir_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_start,
    input  wire shfir_pkg::t_mac_ctl                      i_ctl,
    input  wire logic signed [shfir_pkg::SAMPLE_BITS-1:0] i_tap_l,
    input  wire logic signed [shfir_pkg::SAMPLE_BITS-1:0] i_tap_r,
    input  wire logic signed [shfir_pkg::SAMPLE_BITS-1:0] i_hist_l,
    input  wire logic signed [shfir_pkg::SAMPLE_BITS-1:0] i_hist_r,
    output logic                                          o_done,
    output logic signed [shfir_pkg::SAMPLE_BITS-1:0]      o_left,
    output logic signed [shfir_pkg::SAMPLE_BITS-1:0]      o_right
);

    localparam int unsigned SB     = shfir_pkg::SAMPLE_BITS;
    localparam int unsigned AW     = $clog2(MAX_TAPS);
    localparam int unsigned PROD_W = 2 * SB;
    localparam int unsigned ACC_W  = PROD_W + AW + 1;

    localparam logic signed [ACC_W:0] HALF   = (ACC_W + 1)'(1) << (SB - 2);
    localparam logic signed [ACC_W:0] SAT_HI = ((ACC_W + 1)'(1) << (SB - 1)) - (ACC_W + 1)'(1);
    localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_W-1:0] r_prod_l;
    logic signed [PROD_W-1:0] r_prod_r;
    shfir_pkg::t_mac_ctl      r_prod_ctl;
    logic signed [ACC_W-1:0]  r_acc_l;
    logic signed [ACC_W-1:0]  r_acc_r;
    logic                     r_done;

    always_ff @(posedge i_clk) begin
        r_prod_l <= i_tap_l * i_hist_l;
        r_prod_r <= i_tap_r * i_hist_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_ctl <= '0;
        end else begin
            r_prod_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_prod_ctl.valid) begin
            if (r_prod_ctl.first) begin
                r_acc_l <= ACC_W'(r_prod_l);
                r_acc_r <= ACC_W'(r_prod_r);
            end else begin
                r_acc_l <= r_acc_l + ACC_W'(r_prod_l);
                r_acc_r <= r_acc_r + ACC_W'(r_prod_r);
            end
        end
    end

    // Done is cleared when an item starts and set once its last product is summed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (i_start) begin
            r_done <= 1'b0;
        end else if (r_prod_ctl.valid && r_prod_ctl.last) begin
            r_done <= 1'b1;
        end
    end

    function automatic logic signed [SB-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] v_sum;
        logic signed [ACC_W:0] v_shr;
        logic signed [ACC_W:0] v_sat;
        v_sum = (ACC_W + 1)'(acc) + HALF;
        v_shr = v_sum >>> (SB - 1);
        if (v_shr > SAT_HI) begin
            v_sat = SAT_HI;
        end else if (v_shr < SAT_LO) begin
            v_sat = SAT_LO;
        end else begin
            v_sat = v_shr;
        end
        return v_sat[SB-1:0];
    endfunction

    assign o_done  = r_done;
    assign o_left  = round_sat(r_acc_l);
    assign o_right = round_sat(r_acc_r);

endmodule

`default_nettype wire

// ----- rtl/stereo_hrir_fir_convolver.sv -----
// Stereo FIR convolver: one MAC per channel per tap, sequenced over tap memories.
// An audio beat runs through the tap and history reads, the product and accumulate registers and the output register;
// the next beat is accepted only once the result is loaded into the output register, set by the single shared MAC pair.
// A tap load beat writes the tap memory and gives no result.
// After reset a clearing pass over all MAX_TAPS addresses zeroes history and taps; no beat is taken then.
// Depends on shfir_pkg and shfir_mac.
`timescale 1ns / 1ps
`default_nettype none

module stereo_hrir_fir_convolver #(
    parameter int unsigned MAX_TAPS = shfir_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire shfir_pkg::t_in_item                 i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output shfir_pkg::t_out_item                     o_out_data,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [shfir_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [shfir_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [shfir_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                     pready
);

    localparam int unsigned SB = shfir_pkg::SAMPLE_BITS;
    localparam int unsigned AW = $clog2(MAX_TAPS);
    localparam int unsigned CW = shfir_pkg::TAP_COUNT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    shfir_pkg::t_state r_state;
    shfir_pkg::t_state n_state;

    logic [CW-1:0]     r_tap_count;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_k;
    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     r_last;

    logic [2*SB-1:0]   r_tap_mem [MAX_TAPS];
    logic [2*SB-1:0]   r_hist_mem [MAX_TAPS];
    logic [2*SB-1:0]   r_tap_q;
    logic [2*SB-1:0]   r_hist_q;
    shfir_pkg::t_mac_ctl r_rd_ctl;

    logic              r_out_valid;
    shfir_pkg::t_out_item r_out_data;

    logic              in_accept;
    logic              sample_accept;
    logic              load_accept;
    logic              tap_idx_ok;
    logic              clearing;
    logic              issue;
    logic              load_out;
    logic [AW-1:0]     n_last;
    logic [31:0]       v_cnt;

    logic              cfg_write;
    logic              cfg_hit;

    logic              mac_done;
    logic signed [SB-1:0] mac_left;
    logic signed [SB-1:0] mac_right;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[shfir_pkg::APB_ADDR_W-1:2] == shfir_pkg::REG_TAP_COUNT);
    assign cfg_write = psel && penable && pwrite && cfg_hit;
    assign prdata    = cfg_hit ? shfir_pkg::APB_DATA_W'(r_tap_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= CW'(shfir_pkg::TAP_COUNT_RESET);
        end else if (cfg_write) begin
            r_tap_count <= pwdata[CW-1:0];
        end
    end

    // Taps in use, with zero taken as one and large counts held to the memory depth.
    always_comb begin
        v_cnt = 32'(r_tap_count);
        if (v_cnt == 32'd0) begin
            v_cnt = 32'd1;
        end
        if (v_cnt > 32'(MAX_TAPS)) begin
            v_cnt = 32'(MAX_TAPS);
        end
        n_last = AW'(v_cnt - 32'd1);
    end

    assign in_accept     = i_in_valid && o_in_ready;
    assign sample_accept = in_accept && (i_in_data.mode == shfir_pkg::MODE_SAMPLE);
    assign load_accept   = in_accept && (i_in_data.mode == shfir_pkg::MODE_LOAD);
    assign tap_idx_ok    = 32'(i_in_data.tap_index) < 32'(MAX_TAPS);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            shfir_pkg::ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = shfir_pkg::ST_IDLE;
                end
            end
            shfir_pkg::ST_IDLE: begin
                if (sample_accept) begin
                    n_state = shfir_pkg::ST_RUN;
                end
            end
            shfir_pkg::ST_RUN: begin
                if (r_k == r_last) begin
                    n_state = shfir_pkg::ST_DRAIN;
                end
            end
            shfir_pkg::ST_DRAIN: begin
                if (mac_done) begin
                    n_state = shfir_pkg::ST_FINISH;
                end
            end
            shfir_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = shfir_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shfir_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready = 1'b0;
        clearing   = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            shfir_pkg::ST_CLEAR:  clearing   = 1'b1;
            shfir_pkg::ST_IDLE:   o_in_ready = 1'b1;
            shfir_pkg::ST_RUN:    issue      = 1'b1;
            shfir_pkg::ST_DRAIN:  issue      = 1'b0;
            shfir_pkg::ST_FINISH: load_out   = !r_out_valid || i_out_ready;
            default:              o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= shfir_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_head     <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (sample_accept) begin
                r_head <= (r_head == LAST_ADDR) ? '0 : r_head + AW'(1);
            end
        end
    end

    // Tap counter walks up while the history pointer walks back from the newest sample.
    always_ff @(posedge i_clk) begin
        if (sample_accept) begin
            r_k    <= '0;
            r_ptr  <= r_head;
            r_last <= n_last;
        end else if (issue) begin
            r_k   <= r_k + AW'(1);
            r_ptr <= (r_ptr == '0) ? LAST_ADDR : r_ptr - AW'(1);
        end
    end

    // Tap memory: left tap in the upper half, right tap in the lower half.
    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_tap_mem[r_clr_addr] <= '0;
        end else if (load_accept && tap_idx_ok) begin
            r_tap_mem[AW'(i_in_data.tap_index)] <= {i_in_data.tap_left, i_in_data.tap_right};
        end
        r_tap_q <= r_tap_mem[r_k];
    end

    // History memory, same layout.
    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_hist_mem[r_clr_addr] <= '0;
        end else if (sample_accept) begin
            r_hist_mem[r_head] <= {i_in_data.left_sample, i_in_data.right_sample};
        end
        r_hist_q <= r_hist_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl.valid <= issue;
            r_rd_ctl.first <= issue && (r_k == '0);
            r_rd_ctl.last  <= issue && (r_k == r_last);
        end
    end

    shfir_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sample_accept),
        .i_ctl    (r_rd_ctl),
        .i_tap_l  ($signed(r_tap_q[2*SB-1:SB])),
        .i_tap_r  ($signed(r_tap_q[SB-1:0])),
        .i_hist_l ($signed(r_hist_q[2*SB-1:SB])),
        .i_hist_r ($signed(r_hist_q[SB-1:0])),
        .o_done   (mac_done),
        .o_left   (mac_left),
        .o_right  (mac_right)
    );

    // Output register holds a finished beat until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data.left_out  <= mac_left;
            r_out_data.right_out <= mac_right;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
